// ===== rtl/mafm_pkg.sv =====
// Shared types and codes for the memory access footprint monitor.
// Holds the request and response word structs, op codes and bank codes.
// No dependencies; imported by memory_access_footprint_monitor_top.
`timescale 1ns / 1ps

package mafm_pkg;

	localparam int ADDR_W      = 24;
	localparam int QINDEX_W    = 18;
	localparam int OFFSET_W    = 17;
	localparam int COUNT_OUT_W = 48;

	typedef enum logic [1:0] {
		OP_ACCESS = 2'd0,
		OP_PAGE   = 2'd1,
		OP_WORD   = 2'd2,
		OP_TOTALS = 2'd3
	} op_t;

	localparam logic [1:0] AREA_X = 2'd0;
	localparam logic [1:0] AREA_Y = 2'd1;

	localparam logic [1:0] BANK_X   = 2'd0;
	localparam logic [1:0] BANK_Y   = 2'd1;
	localparam logic [1:0] BANK_P   = 2'd2;
	localparam logic [1:0] BANK_EXT = 2'd3;

	localparam logic [1:0] FLAG_READ  = 2'b01;
	localparam logic [1:0] FLAG_WRITE = 2'b10;

	localparam logic [QINDEX_W-1:0] QSEL_BANK = 18'd0;
	localparam logic [QINDEX_W-1:0] QSEL_PC   = 18'd1;

	typedef struct packed {
		op_t                 op;
		logic [1:0]          area;
		logic                is_write;
		logic [ADDR_W-1:0]   addr;
		logic [ADDR_W-1:0]   pc;
		logic [1:0]          query_bank;
		logic [QINDEX_W-1:0] query_index;
	} req_word_t;

	typedef struct packed {
		logic                   accepted;
		logic [1:0]             bank;
		logic [OFFSET_W-1:0]    offset;
		logic [1:0]             word_flags;
		logic                   pc_was_seen;
		logic [COUNT_OUT_W-1:0] count_a;
		logic [COUNT_OUT_W-1:0] count_b;
	} rsp_word_t;

endpackage

// ===== rtl/memory_access_footprint_monitor_top.sv =====
// Top level of the memory access footprint monitor.
// Depends on mafm_pkg for word types and codes, and on mafm_ram for storage.
// Per-word flags, the PC-seen map and the page counters live in three RAMs.
//
// Usage:
//   The req channel takes one word per access or query; the rsp channel
//   returns exactly one word for each, in order. Both use valid and ready.
//   An access word marks the PC map, sets the read or written flag of the
//   addressed word and bumps page and bank counters, all saturating.
//   Query words read page counters, word flags with the PC bit, or the bank
//   and PC totals.
//   Each accepted word is held in the working stage, which reads the RAMs
//   at acceptance, and moves to the output register, writing the RAMs back,
//   when that register is free. Throughput is one word per cycle while the
//   receiver takes responses: a one-entry write forwarding register per RAM
//   covers a back-to-back word hitting the same entry.
//   After reset the block sweeps all RAMs to zero, one entry per cycle, over
//   3*BRIDGE_WORDS + (TOTAL_WORDS - BRIDGE_WORDS) entries (524288 with the
//   default sizes); req_ready stays low during that sweep.
//   When the receiver stalls, the finished response waits in the output
//   register while one more word is read into the working stage; further
//   words are held off until the output register frees.
`timescale 1ns / 1ps

module memory_access_footprint_monitor_top #(
	parameter int BRIDGE_WORDS = 131072,
	parameter int TOTAL_WORDS  = 262144,
	parameter int PAGE_WORDS   = 256,
	parameter int COUNT_BITS   = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  mafm_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output mafm_pkg::rsp_word_t rsp
);

	import mafm_pkg::*;

	localparam int EXT_WORDS      = (TOTAL_WORDS > BRIDGE_WORDS) ?
	                                (TOTAL_WORDS - BRIDGE_WORDS) : 0;
	localparam int BIG_WORDS      = (BRIDGE_WORDS >= EXT_WORDS) ? BRIDGE_WORDS : EXT_WORDS;
	localparam int PAGES_PER_BANK = (BIG_WORDS + PAGE_WORDS - 1) / PAGE_WORDS;
	localparam int INT_PAGES      = (BRIDGE_WORDS + PAGE_WORDS - 1) / PAGE_WORDS;
	localparam int EXT_PAGES      = (EXT_WORDS + PAGE_WORDS - 1) / PAGE_WORDS;
	localparam int FLAG_DEPTH     = 3 * BRIDGE_WORDS + EXT_WORDS;
	localparam int PG_DEPTH       = 4 * PAGES_PER_BANK;
	localparam int PC_DEPTH       = TOTAL_WORDS;
	localparam int FLAG_AW        = $clog2(FLAG_DEPTH);
	localparam int PG_AW          = $clog2(PG_DEPTH);
	localparam int PC_AW          = $clog2(PC_DEPTH);
	localparam int OFF_W          = $clog2(BIG_WORDS);
	localparam int PAGE_SH        = $clog2(PAGE_WORDS);
	localparam int CW             = COUNT_BITS;
	localparam int RECIP_SH       = OFF_W + PAGE_SH;
	localparam int PROD_W         = 2 * OFF_W + 2;

	// Page number by reciprocal multiplication; exact for every offset below 2**OFF_W.
	localparam longint RECIP_M    = ((longint'(1) << RECIP_SH) + PAGE_WORDS - 1) / PAGE_WORDS;

	localparam logic [24:0] TOTAL_C     = 25'(TOTAL_WORDS);
	localparam logic [24:0] BRIDGE_C    = 25'(BRIDGE_WORDS);
	localparam logic [24:0] EXT_WORDS_C = 25'(EXT_WORDS);
	localparam logic [24:0] INT_PAGES_C = 25'(INT_PAGES);
	localparam logic [24:0] EXT_PAGES_C = 25'(EXT_PAGES);

	localparam logic [FLAG_AW-1:0] CLR_LAST   = FLAG_AW'(FLAG_DEPTH - 1);
	localparam logic [FLAG_AW:0]   PG_DEPTH_C = (FLAG_AW + 1)'(PG_DEPTH);
	localparam logic [FLAG_AW:0]   PC_DEPTH_C = (FLAG_AW + 1)'(PC_DEPTH);
	localparam logic [PROD_W-1:0]  RECIP_C    = PROD_W'(RECIP_M);

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (v == {CW{1'b1}}) ? v : v + CW'(1);
	endfunction

	function automatic logic [FLAG_AW-1:0] slot_of(input logic [1:0] b,
	                                               input logic [OFF_W-1:0] o);
		logic [FLAG_AW-1:0] base;
		case (b)
			BANK_X:  base = '0;
			BANK_Y:  base = FLAG_AW'(BRIDGE_WORDS);
			BANK_P:  base = FLAG_AW'(2 * BRIDGE_WORDS);
			default: base = FLAG_AW'(3 * BRIDGE_WORDS);
		endcase
		return base + FLAG_AW'(o);
	endfunction

	function automatic logic [PG_AW-1:0] page_of(input logic [1:0] b,
	                                             input logic [PG_AW-1:0] p);
		logic [PG_AW-1:0] base;
		case (b)
			BANK_X:  base = '0;
			BANK_Y:  base = PG_AW'(PAGES_PER_BANK);
			BANK_P:  base = PG_AW'(2 * PAGES_PER_BANK);
			default: base = PG_AW'(3 * PAGES_PER_BANK);
		endcase
		return base + p;
	endfunction

	// Handshake and sweep control.
	logic               req_fire;
	logic               s1_fire;
	logic               s1_valid_q;
	logic               rsp_valid_q;
	logic               clr_busy_q;
	logic [FLAG_AW-1:0] clr_idx_q;

	// Decode of the incoming word.
	logic [24:0]        addr_x;
	logic [24:0]        pc_x;
	logic [24:0]        qi_x;
	logic               addr_ok;
	logic               addr_ext;
	logic [1:0]         acc_bank;
	logic [OFF_W-1:0]   acc_off;
	logic [PROD_W-1:0]  page_prod;
	logic               q_words_ok;
	logic               q_pages_ok;
	logic               pc_ok;
	logic               qpc_ok;
	logic               sel_bank;
	logic               sel_pc;
	logic               d_acc;
	logic [1:0]         d_bank;
	logic [OFF_W-1:0]   d_off;
	logic [FLAG_AW-1:0] d_fslot;
	logic [PG_AW-1:0]   d_pg;
	logic [PC_AW-1:0]   d_pcaddr;

	// Working stage.
	op_t                op_s1;
	logic               wr_s1;
	logic               acc_s1;
	logic [1:0]         bank_s1;
	logic [OFF_W-1:0]   off_s1;
	logic [FLAG_AW-1:0] fslot_s1;
	logic [PG_AW-1:0]   pg_s1;
	logic [PC_AW-1:0]   pcaddr_s1;
	logic               pcok_s1;
	logic               pcext_s1;
	logic               selpc_s1;

	// RAM ports.
	logic               f_we;
	logic [FLAG_AW-1:0] f_wa;
	logic [1:0]         f_wd;
	logic [1:0]         f_rd;
	logic               pg_we;
	logic [PG_AW-1:0]   pg_wa;
	logic [2*CW-1:0]    pg_wd;
	logic [2*CW-1:0]    pg_rd;
	logic               pc_we;
	logic [PC_AW-1:0]   pc_wa;
	logic               pc_wd;
	logic               pc_rd;

	// Write forwarding for a word that read an entry at the edge it was written.
	logic               ffwd_v_q;
	logic [FLAG_AW-1:0] ffwd_a_q;
	logic [1:0]         ffwd_d_q;
	logic               pgfwd_v_q;
	logic [PG_AW-1:0]   pgfwd_a_q;
	logic [2*CW-1:0]    pgfwd_d_q;
	logic               pcfwd_v_q;
	logic [PC_AW-1:0]   pcfwd_a_q;

	// Read-modify-write values.
	logic [1:0]         f_cur;
	logic [1:0]         f_new;
	logic [CW-1:0]      rd_cur;
	logic [CW-1:0]      wrc_cur;
	logic [CW-1:0]      rd_new;
	logic [CW-1:0]      wrc_new;
	logic               pcb_cur;
	logic               upd_acc;
	logic               upd_pc;

	logic [CW-1:0]      bank_rd_q [4];
	logic [CW-1:0]      bank_wr_q [4];
	logic [CW-1:0]      pc_int_q;
	logic [CW-1:0]      pc_ext_q;

	rsp_word_t          rsp_d;
	rsp_word_t          rsp_q;

	assign s1_fire   = s1_valid_q && (!rsp_valid_q || rsp_ready);
	assign req_ready = !clr_busy_q && (!s1_valid_q || s1_fire);
	assign req_fire  = req_valid && req_ready;

	// Decode: range checks and RAM addresses for the incoming word.
	always_comb begin
		addr_x     = {1'b0, req.addr};
		pc_x       = {1'b0, req.pc};
		qi_x       = 25'(req.query_index);
		addr_ok    = addr_x < TOTAL_C;
		addr_ext   = addr_x >= BRIDGE_C;
		pc_ok      = pc_x < TOTAL_C;
		qpc_ok     = qi_x < TOTAL_C;
		sel_bank   = req.query_index == QSEL_BANK;
		sel_pc     = req.query_index == QSEL_PC;
		q_words_ok = (req.query_bank == BANK_EXT) ? (qi_x < EXT_WORDS_C) : (qi_x < BRIDGE_C);
		q_pages_ok = (req.query_bank == BANK_EXT) ? (qi_x < EXT_PAGES_C) :
		                                            (qi_x < INT_PAGES_C);

		if (addr_ext) begin
			acc_bank = BANK_EXT;
			acc_off  = OFF_W'(addr_x - BRIDGE_C);
		end else begin
			case (req.area)
				AREA_X:  acc_bank = BANK_X;
				AREA_Y:  acc_bank = BANK_Y;
				default: acc_bank = BANK_P;
			endcase
			acc_off = OFF_W'(addr_x);
		end
		page_prod = PROD_W'(acc_off) * RECIP_C;

		case (req.op)
			OP_ACCESS: d_acc = addr_ok;
			OP_PAGE:   d_acc = q_pages_ok;
			OP_WORD:   d_acc = q_words_ok;
			default:   d_acc = sel_bank || sel_pc;
		endcase

		if (req.op == OP_ACCESS) begin
			d_bank   = acc_bank;
			d_off    = acc_off;
			d_pg     = page_of(acc_bank, PG_AW'(page_prod >> RECIP_SH));
			d_pcaddr = PC_AW'(req.pc);
		end else begin
			d_bank   = req.query_bank;
			d_off    = OFF_W'(req.query_index);
			d_pg     = page_of(req.query_bank, PG_AW'(req.query_index));
			d_pcaddr = PC_AW'(req.query_index);
		end
		d_fslot = slot_of(d_bank, d_off);
	end

	// Working stage payload.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_s1     <= req.op;
			wr_s1     <= req.is_write;
			acc_s1    <= d_acc;
			bank_s1   <= d_bank;
			off_s1    <= d_off;
			fslot_s1  <= d_fslot;
			pg_s1     <= d_pg;
			pcaddr_s1 <= d_pcaddr;
			pcok_s1   <= (req.op == OP_ACCESS) ? pc_ok : qpc_ok;
			pcext_s1  <= pc_x >= BRIDGE_C;
			selpc_s1  <= sel_pc;
		end
	end

	// Read-modify-write on the stored state.
	always_comb begin
		f_cur = (ffwd_v_q && ffwd_a_q == fslot_s1) ? ffwd_d_q : f_rd;
		if (pgfwd_v_q && pgfwd_a_q == pg_s1) begin
			wrc_cur = pgfwd_d_q[2*CW-1:CW];
			rd_cur  = pgfwd_d_q[CW-1:0];
		end else begin
			wrc_cur = pg_rd[2*CW-1:CW];
			rd_cur  = pg_rd[CW-1:0];
		end
		pcb_cur = (pcfwd_v_q && pcfwd_a_q == pcaddr_s1) ? 1'b1 : pc_rd;

		f_new   = f_cur | (wr_s1 ? FLAG_WRITE : FLAG_READ);
		rd_new  = wr_s1 ? rd_cur : sat_inc(rd_cur);
		wrc_new = wr_s1 ? sat_inc(wrc_cur) : wrc_cur;

		upd_acc = s1_fire && op_s1 == OP_ACCESS && acc_s1;
		upd_pc  = s1_fire && op_s1 == OP_ACCESS && pcok_s1;
	end

	// RAM write ports: the reset sweep takes them until it is done.
	always_comb begin
		if (clr_busy_q) begin
			f_we  = 1'b1;
			f_wa  = clr_idx_q;
			f_wd  = '0;
			pg_we = {1'b0, clr_idx_q} < PG_DEPTH_C;
			pg_wa = PG_AW'(clr_idx_q);
			pg_wd = '0;
			pc_we = {1'b0, clr_idx_q} < PC_DEPTH_C;
			pc_wa = PC_AW'(clr_idx_q);
			pc_wd = 1'b0;
		end else begin
			f_we  = upd_acc;
			f_wa  = fslot_s1;
			f_wd  = f_new;
			pg_we = upd_acc;
			pg_wa = pg_s1;
			pg_wd = {wrc_new, rd_new};
			pc_we = upd_pc;
			pc_wa = pcaddr_s1;
			pc_wd = 1'b1;
		end
	end

	mafm_ram #(
		.WIDTH (2),
		.DEPTH (FLAG_DEPTH)
	) u_flag_ram (
		.clk     (clk),
		.wr_en   (f_we),
		.wr_addr (f_wa),
		.wr_data (f_wd),
		.rd_en   (req_fire),
		.rd_addr (d_fslot),
		.rd_data (f_rd)
	);

	mafm_ram #(
		.WIDTH (2 * CW),
		.DEPTH (PG_DEPTH)
	) u_page_ram (
		.clk     (clk),
		.wr_en   (pg_we),
		.wr_addr (pg_wa),
		.wr_data (pg_wd),
		.rd_en   (req_fire),
		.rd_addr (d_pg),
		.rd_data (pg_rd)
	);

	mafm_ram #(
		.WIDTH (1),
		.DEPTH (PC_DEPTH)
	) u_pc_ram (
		.clk     (clk),
		.wr_en   (pc_we),
		.wr_addr (pc_wa),
		.wr_data (pc_wd),
		.rd_en   (req_fire),
		.rd_addr (d_pcaddr),
		.rd_data (pc_rd)
	);

	// Response word for the item in the working stage.
	always_comb begin
		rsp_d             = '0;
		rsp_d.accepted    = acc_s1;
		case (op_s1)
			OP_ACCESS: begin
				rsp_d.pc_was_seen = pcok_s1;
				if (acc_s1) begin
					rsp_d.bank       = bank_s1;
					rsp_d.offset     = OFFSET_W'(off_s1);
					rsp_d.word_flags = f_new;
					rsp_d.count_a    = COUNT_OUT_W'(rd_new);
					rsp_d.count_b    = COUNT_OUT_W'(wrc_new);
				end
			end
			OP_PAGE: begin
				if (acc_s1) begin
					rsp_d.count_a = COUNT_OUT_W'(rd_cur);
					rsp_d.count_b = COUNT_OUT_W'(wrc_cur);
				end
			end
			OP_WORD: begin
				rsp_d.pc_was_seen = pcok_s1 && pcb_cur;
				if (acc_s1) begin
					rsp_d.word_flags = f_cur;
				end
			end
			default: begin
				if (acc_s1 && selpc_s1) begin
					rsp_d.count_a = COUNT_OUT_W'(pc_int_q);
					rsp_d.count_b = COUNT_OUT_W'(pc_ext_q);
				end else if (acc_s1) begin
					rsp_d.count_a = COUNT_OUT_W'(bank_rd_q[bank_s1]);
					rsp_d.count_b = COUNT_OUT_W'(bank_wr_q[bank_s1]);
				end
			end
		endcase
	end

	// Control state, bank and PC counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			clr_busy_q  <= 1'b1;
			clr_idx_q   <= '0;
			ffwd_v_q    <= 1'b0;
			pgfwd_v_q   <= 1'b0;
			pcfwd_v_q   <= 1'b0;
			pc_int_q    <= '0;
			pc_ext_q    <= '0;
			for (int i = 0; i < 4; i++) begin
				bank_rd_q[i] <= '0;
				bank_wr_q[i] <= '0;
			end
		end else begin
			if (clr_busy_q) begin
				if (clr_idx_q == CLR_LAST) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_idx_q <= clr_idx_q + FLAG_AW'(1);
				end
			end

			if (req_fire) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end

			if (s1_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (clr_busy_q) begin
				ffwd_v_q  <= 1'b0;
				pgfwd_v_q <= 1'b0;
				pcfwd_v_q <= 1'b0;
			end else begin
				if (upd_acc) begin
					ffwd_v_q  <= 1'b1;
					pgfwd_v_q <= 1'b1;
				end
				if (upd_pc) begin
					pcfwd_v_q <= 1'b1;
				end
			end

			if (upd_acc) begin
				if (wr_s1) begin
					bank_wr_q[bank_s1] <= sat_inc(bank_wr_q[bank_s1]);
				end else begin
					bank_rd_q[bank_s1] <= sat_inc(bank_rd_q[bank_s1]);
				end
			end
			if (upd_pc) begin
				if (pcext_s1) begin
					pc_ext_q <= sat_inc(pc_ext_q);
				end else begin
					pc_int_q <= sat_inc(pc_int_q);
				end
			end
		end
	end

	// Forwarding payload and the output register.
	always_ff @(posedge clk) begin
		if (upd_acc) begin
			ffwd_a_q  <= fslot_s1;
			ffwd_d_q  <= f_new;
			pgfwd_a_q <= pg_s1;
			pgfwd_d_q <= {wrc_new, rd_new};
		end
		if (upd_pc) begin
			pcfwd_a_q <= pcaddr_s1;
		end
		if (s1_fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/mafm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Reading and writing one address at the same edge returns the old contents.
// No dependencies.
`timescale 1ns / 1ps

module mafm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== verif/memory_access_footprint_monitor_top_tb.sv =====
// Self-checking testbench for the memory access footprint monitor top level.
// Drives req words, predicts every rsp word with its own model of the stores
// and compares the two; depends only on mafm_pkg and the RTL under verif.
`timescale 1ns / 1ps

module memory_access_footprint_monitor_top_tb;
	import mafm_pkg::*;

	localparam int BRIDGE_WORDS   = 131072;
	localparam int TOTAL_WORDS    = 262144;
	localparam int PAGE_WORDS     = 256;
	localparam int COUNT_BITS     = 48;
	localparam int EXT_WORDS      = TOTAL_WORDS - BRIDGE_WORDS;
	localparam int BIG_WORDS      = (BRIDGE_WORDS >= EXT_WORDS) ? BRIDGE_WORDS : EXT_WORDS;
	localparam int PAGES_PER_BANK = (BIG_WORDS + PAGE_WORDS - 1) / PAGE_WORDS;
	localparam int INT_PAGES      = (BRIDGE_WORDS + PAGE_WORDS - 1) / PAGE_WORDS;
	localparam int EXT_PAGES      = (EXT_WORDS + PAGE_WORDS - 1) / PAGE_WORDS;
	localparam int FLAG_DEPTH     = 3 * BRIDGE_WORDS + EXT_WORDS;
	localparam logic [COUNT_OUT_W-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [1:0] AREA_P     = 2'd2;
	localparam logic [1:0] AREA_ALIAS = 2'd3;

	localparam int     CLK_PERIOD     = 20;
	localparam int     HOLDOFF_CYCLES = 60;
	// The limit covers the clearing sweep over all 524288 entries, with ample margin.
	localparam longint LIMIT_NS       = 64'd2_000_000 * CLK_PERIOD;

	typedef struct packed {
		logic [1:0]          area;
		logic [ADDR_W-1:0]   addr;
		logic [1:0]          bank;
		logic [OFFSET_W-1:0] offset;
	} spot_t;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_word_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_word_t rsp;

	// Model of the monitor's stores.
	bit [1:0]             word_flags_mem [FLAG_DEPTH];
	bit                   pc_seen_mem [TOTAL_WORDS];
	bit [COUNT_OUT_W-1:0] page_reads [4*PAGES_PER_BANK];
	bit [COUNT_OUT_W-1:0] page_writes [4*PAGES_PER_BANK];
	bit [COUNT_OUT_W-1:0] bank_reads [4];
	bit [COUNT_OUT_W-1:0] bank_writes [4];
	bit [COUNT_OUT_W-1:0] pc_internal_hits;
	bit [COUNT_OUT_W-1:0] pc_external_hits;

	rsp_word_t       expected_rsp[$];
	spot_t           recent_spots[$];
	logic [ADDR_W-1:0] recent_pcs[$];

	int unsigned send_idle_pct;
	int unsigned rsp_stall_pct;
	int unsigned holdoff_left;
	int unsigned mismatch_count;
	int unsigned words_sent;
	int unsigned access_count;
	int unsigned rsp_checked;
	int unsigned input_stall_cycles;

	memory_access_footprint_monitor_top #(
		.BRIDGE_WORDS(BRIDGE_WORDS),
		.TOTAL_WORDS (TOTAL_WORDS),
		.PAGE_WORDS  (PAGE_WORDS),
		.COUNT_BITS  (COUNT_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic bit [COUNT_OUT_W-1:0] sat_bump(input bit [COUNT_OUT_W-1:0] v);
		return (v == COUNT_MAX) ? v : v + 1'b1;
	endfunction

	// Applies one word to the model stores and returns the response it must produce.
	function automatic rsp_word_t predict_footprint(input req_word_t w);
		rsp_word_t   r;
		logic [1:0]  b;
		int unsigned o;
		int unsigned slot;
		int unsigned pg;
		int unsigned lim;
		r = '0;
		case (w.op)
			OP_ACCESS: begin
				if (w.pc < TOTAL_WORDS) begin
					pc_seen_mem[w.pc] = 1'b1;
					r.pc_was_seen = 1'b1;
					if (w.pc >= BRIDGE_WORDS)
						pc_external_hits = sat_bump(pc_external_hits);
					else
						pc_internal_hits = sat_bump(pc_internal_hits);
				end
				if (w.addr < TOTAL_WORDS) begin
					if (w.addr >= BRIDGE_WORDS) begin
						b = BANK_EXT;
						o = w.addr - BRIDGE_WORDS;
					end else begin
						b = (w.area == AREA_X || w.area == AREA_Y) ? w.area : BANK_P;
						o = w.addr;
					end
					lim = (b == BANK_EXT) ? EXT_WORDS : BRIDGE_WORDS;
					if (o < lim) begin
						slot = b * BRIDGE_WORDS + o;
						pg = b * PAGES_PER_BANK + o / PAGE_WORDS;
						word_flags_mem[slot] = word_flags_mem[slot] |
							(w.is_write ? FLAG_WRITE : FLAG_READ);
						if (w.is_write) begin
							page_writes[pg] = sat_bump(page_writes[pg]);
							bank_writes[b] = sat_bump(bank_writes[b]);
						end else begin
							page_reads[pg] = sat_bump(page_reads[pg]);
							bank_reads[b] = sat_bump(bank_reads[b]);
						end
						r.accepted = 1'b1;
						r.bank = b;
						r.offset = o[OFFSET_W-1:0];
						r.word_flags = word_flags_mem[slot];
						r.count_a = page_reads[pg];
						r.count_b = page_writes[pg];
					end
				end
			end
			OP_PAGE: begin
				lim = (w.query_bank == BANK_EXT) ? EXT_PAGES : INT_PAGES;
				if (w.query_index < lim) begin
					pg = w.query_bank * PAGES_PER_BANK + w.query_index;
					r.accepted = 1'b1;
					r.count_a = page_reads[pg];
					r.count_b = page_writes[pg];
				end
			end
			OP_WORD: begin
				lim = (w.query_bank == BANK_EXT) ? EXT_WORDS : BRIDGE_WORDS;
				if (w.query_index < lim) begin
					r.accepted = 1'b1;
					r.word_flags = word_flags_mem[w.query_bank * BRIDGE_WORDS + w.query_index];
				end
				// The PC bit is looked up even when the word offset is out of range.
				if (w.query_index < TOTAL_WORDS)
					r.pc_was_seen = pc_seen_mem[w.query_index];
			end
			default: begin
				if (w.query_index == QSEL_BANK) begin
					r.accepted = 1'b1;
					r.count_a = bank_reads[w.query_bank];
					r.count_b = bank_writes[w.query_bank];
				end else if (w.query_index == QSEL_PC) begin
					r.accepted = 1'b1;
					r.count_a = pc_internal_hits;
					r.count_b = pc_external_hits;
				end
			end
		endcase
		return r;
	endfunction

	function automatic req_word_t pack_req(input op_t op, input logic [1:0] area,
			input logic wr, input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] pc,
			input logic [1:0] qb, input logic [QINDEX_W-1:0] qi);
		req_word_t w;
		w.op = op;
		w.area = area;
		w.is_write = wr;
		w.addr = addr;
		w.pc = pc;
		w.query_bank = qb;
		w.query_index = qi;
		return w;
	endfunction

	// Random word biased toward a few hot pages and recently touched words,
	// so that flags, page counters and the PC map see repeated hits.
	function automatic req_word_t make_random_word();
		req_word_t   w;
		int unsigned pick;
		int unsigned pc_pick;
		spot_t       s;
		w.area = $urandom_range(3);
		w.is_write = $urandom_range(1);
		w.addr = $urandom;
		w.pc = $urandom;
		w.query_bank = $urandom_range(3);
		w.query_index = $urandom;
		pick = $urandom_range(99);
		if (pick < 55)
			w.op = OP_ACCESS;
		else if (pick < 70)
			w.op = OP_PAGE;
		else if (pick < 85)
			w.op = OP_WORD;
		else
			w.op = OP_TOTALS;
		pick = $urandom_range(99);
		case (w.op)
			OP_ACCESS: begin
				if (pick < 35) begin
					case ($urandom_range(3))
						0: w.addr = 0;
						1: w.addr = BRIDGE_WORDS - PAGE_WORDS;
						2: w.addr = BRIDGE_WORDS;
						default: w.addr = TOTAL_WORDS - PAGE_WORDS;
					endcase
					w.addr = w.addr + ($urandom_range(1) ? PAGE_WORDS - 16 : 0) +
						$urandom_range(15);
				end else if (pick < 60 && recent_spots.size() > 0) begin
					s = recent_spots[$urandom_range(recent_spots.size() - 1)];
					w.area = s.area;
					w.addr = s.addr;
				end else if (pick < 85) begin
					w.addr = $urandom_range(TOTAL_WORDS - 1);
				end
				pc_pick = $urandom_range(99);
				if (pc_pick < 45) begin
					w.pc = ($urandom_range(1) ? BRIDGE_WORDS : 0) + $urandom_range(63);
				end else if (pc_pick < 60) begin
					case ($urandom_range(3))
						0: w.pc = BRIDGE_WORDS - 1;
						1: w.pc = BRIDGE_WORDS;
						2: w.pc = TOTAL_WORDS - 1;
						default: w.pc = TOTAL_WORDS;
					endcase
				end else if (pc_pick < 85) begin
					w.pc = $urandom_range(TOTAL_WORDS - 1);
				end
			end
			OP_PAGE: begin
				if (pick < 60 && recent_spots.size() > 0) begin
					s = recent_spots[$urandom_range(recent_spots.size() - 1)];
					w.query_bank = s.bank;
					w.query_index = s.offset / PAGE_WORDS;
				end else if (pick < 80) begin
					w.query_index = $urandom_range(PAGES_PER_BANK);
				end
			end
			OP_WORD: begin
				if (pick < 50 && recent_spots.size() > 0) begin
					s = recent_spots[$urandom_range(recent_spots.size() - 1)];
					w.query_bank = s.bank;
					w.query_index = s.offset;
				end else if (pick < 75 && recent_pcs.size() > 0) begin
					w.query_index = recent_pcs[$urandom_range(recent_pcs.size() - 1)];
				end else if (pick < 85) begin
					w.query_index = $urandom_range(1) ? BRIDGE_WORDS - 1 : BRIDGE_WORDS;
				end
			end
			default: begin
				if (pick < 45)
					w.query_index = QSEL_BANK;
				else if (pick < 90)
					w.query_index = QSEL_PC;
			end
		endcase
		return w;
	endfunction

	// Offers one word at a falling edge and returns at the rising edge that takes it.
	task automatic send_word(input req_word_t w);
		rsp_word_t r;
		spot_t     s;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req = w;
		req_valid = 1'b1;
		@(posedge clk);
		while (req_ready !== 1'b1) begin
			input_stall_cycles++;
			@(posedge clk);
		end
		r = predict_footprint(w);
		expected_rsp = {expected_rsp, r};
		words_sent++;
		if (w.op == OP_ACCESS) begin
			access_count++;
			if (r.accepted) begin
				s.area = w.area;
				s.addr = w.addr;
				s.bank = r.bank;
				s.offset = r.offset;
				recent_spots = {recent_spots, s};
				if (recent_spots.size() > 64)
					void'(recent_spots.pop_front());
			end
			if (r.pc_was_seen) begin
				recent_pcs = {recent_pcs, w.pc};
				if (recent_pcs.size() > 64)
					void'(recent_pcs.pop_front());
			end
		end
	endtask

	// Drops valid and waits until every expected response has been taken.
	task automatic wait_until_drained();
		@(negedge clk);
		req_valid = 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_directed_edges();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		// Same word read then written back to back: flags end up both set.
		send_word(pack_req(OP_ACCESS, AREA_X, 1'b0, 0, 0, 0, 0));
		send_word(pack_req(OP_ACCESS, AREA_X, 1'b1, 0, 0, 0, 0));
		send_word(pack_req(OP_ACCESS, AREA_Y, 1'b1, BRIDGE_WORDS - 1, BRIDGE_WORDS - 1, 0, 0));
		send_word(pack_req(OP_ACCESS, AREA_P, 1'b0, 24'h012345, BRIDGE_WORDS, 0, 0));
		send_word(pack_req(OP_ACCESS, AREA_ALIAS, 1'b1, 24'h000100, TOTAL_WORDS - 1, 0, 0));
		// First external word, with a PC just past the mapped range.
		send_word(pack_req(OP_ACCESS, AREA_X, 1'b1, BRIDGE_WORDS, TOTAL_WORDS, 0, 0));
		send_word(pack_req(OP_ACCESS, AREA_Y, 1'b0, TOTAL_WORDS - 1, 24'hFFFFFF, 0, 0));
		send_word(pack_req(OP_ACCESS, AREA_X, 1'b0, TOTAL_WORDS, 5, 0, 0));
		send_word(pack_req(OP_ACCESS, AREA_P, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 0, 0));
		send_word(pack_req(OP_PAGE, 0, 0, 0, 0, BANK_X, 0));
		send_word(pack_req(OP_PAGE, 0, 0, 0, 0, BANK_EXT, EXT_PAGES - 1));
		send_word(pack_req(OP_PAGE, 0, 0, 0, 0, BANK_P, INT_PAGES));
		send_word(pack_req(OP_PAGE, 0, 0, 0, 0, BANK_Y, 18'h3FFFF));
		send_word(pack_req(OP_WORD, 0, 0, 0, 0, BANK_X, 0));
		send_word(pack_req(OP_WORD, 0, 0, 0, 0, BANK_EXT, EXT_WORDS - 1));
		// Two word offsets out of range whose PC bits are set, then a bank P word that was written.
		send_word(pack_req(OP_WORD, 0, 0, 0, 0, BANK_P, BRIDGE_WORDS));
		send_word(pack_req(OP_WORD, 0, 0, 0, 0, BANK_Y, 18'h3FFFF));
		send_word(pack_req(OP_WORD, 0, 0, 0, 0, BANK_P, 18'h00100));
		send_word(pack_req(OP_TOTALS, 0, 0, 0, 0, BANK_X, QSEL_BANK));
		send_word(pack_req(OP_TOTALS, 0, 0, 0, 0, BANK_Y, QSEL_BANK));
		send_word(pack_req(OP_TOTALS, 0, 0, 0, 0, BANK_P, QSEL_BANK));
		send_word(pack_req(OP_TOTALS, 0, 0, 0, 0, BANK_EXT, QSEL_BANK));
		send_word(pack_req(OP_TOTALS, 0, 0, 0, 0, BANK_X, QSEL_PC));
		send_word(pack_req(OP_TOTALS, 0, 0, 0, 0, BANK_Y, QSEL_PC + 1'b1));
		send_word(pack_req(OP_TOTALS, 0, 0, 0, 0, BANK_EXT, 18'h3FFFF));
	endtask

	task automatic run_random_traffic(input int unsigned n, input int unsigned idle_pct,
			input int unsigned stall_pct);
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		repeat (n) send_word(make_random_word());
	endtask

	// The receiver stops for a long stretch while words keep coming, so the
	// output register and the working stage fill and req_ready must drop.
	task automatic run_output_holdoff();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		holdoff_left = HOLDOFF_CYCLES;
		repeat (24) send_word(make_random_word());
	endtask

	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_left > 0) begin
				rsp_ready = 1'b0;
				holdoff_left--;
			end else begin
				rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
			end
		end
	end

	task automatic check_field(input string field, input logic [COUNT_OUT_W-1:0] want,
			input logic [COUNT_OUT_W-1:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: response %0d field %s expected %h got %h",
					$time, rsp_checked, field, want, got);
		end
	endtask

	initial begin
		rsp_word_t want;
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
				if (expected_rsp.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: response word %h arrived with none expected",
							$time, rsp);
				end else begin
					want = expected_rsp.pop_front();
					check_field("accepted", want.accepted, rsp.accepted);
					check_field("bank", want.bank, rsp.bank);
					check_field("offset", want.offset, rsp.offset);
					check_field("word_flags", want.word_flags, rsp.word_flags);
					check_field("pc_was_seen", want.pc_was_seen, rsp.pc_was_seen);
					check_field("count_a", want.count_a, rsp.count_a);
					check_field("count_b", want.count_b, rsp.count_b);
					rsp_checked++;
				end
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("Run timed out with %0d responses still expected.", expected_rsp.size());
		$display("** memory_access_footprint_monitor_top: FAILED **");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		holdoff_left = 0;
		mismatch_count = 0;
		words_sent = 0;
		access_count = 0;
		rsp_checked = 0;
		input_stall_cycles = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The first word waits out the clearing sweep on req_ready.
		run_directed_edges();
		wait_until_drained();
		run_random_traffic(280, 0, 0);
		run_output_holdoff();
		run_random_traffic(280, 62, 0);
		wait_until_drained();
		run_random_traffic(280, 0, 62);
		run_random_traffic(280, 19, 19);
		rsp_stall_pct = 0;
		wait_until_drained();
		repeat (8) @(posedge clk);

		$display("Sent %0d words (%0d accesses, %0d queries); %0d responses checked.",
			words_sent, access_count, words_sent - access_count, rsp_checked);
		$display("Traffic ran without gaps, with sender and receiver gaps, and through a "
			, "%0d-cycle output hold-off; input was held off %0d cycles in all.",
			HOLDOFF_CYCLES, input_stall_cycles);
		if (mismatch_count == 0 && expected_rsp.size() == 0) begin
			$display("** memory_access_footprint_monitor_top: PASSED **");
		end else begin
			$display("%0d mismatches, %0d responses missing.", mismatch_count,
				expected_rsp.size());
			$display("** memory_access_footprint_monitor_top: FAILED **");
		end
		$finish;
	end

endmodule
